// ===== src/ftpcf_pkg.sv =====
// ============================================================================
// ftpcf_pkg: shared types and constants of the five-tap point curve filter
// Register indexes, request codes, sequencer states and kernel weights.
// ============================================================================
`default_nettype none
package ftpcf_pkg;

  localparam int unsigned MaxPointsDef = 1024;
  localparam int unsigned CoordBitsDef = 32;
  localparam int unsigned IdxBits      = 10;
  localparam int unsigned CntBits      = 11;
  localparam int unsigned CfgIdxBits   = 3;
  localparam int unsigned CfgDataBits  = 16;
  localparam int unsigned WBits        = 6;
  localparam int unsigned ReqBits      = 2;

  typedef enum logic [ReqBits-1:0] {
    REQ_WRITE = 2'd0,
    REQ_RUN   = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_COUNT  = 3'd0,
    REG_KERNEL = 3'd1,
    REG_MODE   = 3'd2,
    REG_ITER   = 3'd3,
    REG_FIRST  = 3'd4,
    REG_LAST   = 3'd5
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_CALC,
    ST_WRITE,
    ST_ACK
  } state_e;

  typedef logic signed [WBits-1:0] weight_t;

  // tap weight: tap 0..4 in middle window, edge uses taps 0..3
  function automatic weight_t mid_weight(input logic [1:0] k, input logic [2:0] t);
    weight_t w;
    w = '0;
    case (k)
      2'd1: begin
        case (t)
          3'd0, 3'd4: w = 6'sd1;
          3'd1, 3'd3: w = 6'sd4;
          default:    w = 6'sd6;
        endcase
      end
      2'd2: begin
        case (t)
          3'd0, 3'd4: w = -6'sd1;
          3'd1, 3'd3: w = -6'sd4;
          default:    w = 6'sd26;
        endcase
      end
      default: begin
        case (t)
          3'd0, 3'd4: w = -6'sd1;
          3'd1, 3'd3: w = 6'sd4;
          default:    w = 6'sd10;
        endcase
      end
    endcase
    return w;
  endfunction

  function automatic weight_t edge_weight(input logic [1:0] k, input logic [2:0] t);
    weight_t w;
    w = '0;
    case (k)
      2'd1: begin
        case (t)
          3'd0:    w = 6'sd6;
          3'd1:    w = 6'sd5;
          3'd2:    w = 6'sd4;
          3'd3:    w = 6'sd1;
          default: w = '0;
        endcase
      end
      2'd2: begin
        case (t)
          3'd0:    w = -6'sd6;
          3'd1:    w = 6'sd27;
          3'd2:    w = -6'sd4;
          3'd3:    w = -6'sd1;
          default: w = '0;
        endcase
      end
      default: begin
        case (t)
          3'd0:    w = 6'sd2;
          3'd1:    w = 6'sd11;
          3'd2:    w = 6'sd4;
          3'd3:    w = -6'sd1;
          default: w = '0;
        endcase
      end
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// ===== src/ftpcf_mem.sv =====
// ============================================================================
// ftpcf_mem: point store memory
// Synchronous memory, one write and one registered read port.
// ============================================================================
`default_nettype none
module ftpcf_mem #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned Width = 96
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

// ===== src/ftpcf_mac.sv =====
// ============================================================================
// ftpcf_mac: tap accumulator
// Accumulates weighted taps for three coordinates, then floors, optionally
// subtracts and saturates the result.
// ============================================================================
`default_nettype none
module ftpcf_mac
  import ftpcf_pkg::*;
#(
  parameter int unsigned CoordBits = 32
) (
  input  wire logic                        clk_i,
  input  wire logic                        clr_i,
  input  wire logic                        acc_i,
  input  wire weight_t                     w_i,
  input  wire logic     [3*CoordBits-1:0]  tap_i,
  input  wire logic                        sub_i,
  input  wire logic     [3*CoordBits-1:0]  ctr_i,
  output logic          [3*CoordBits-1:0]  res_o
);

  localparam int unsigned AccBits  = CoordBits + WBits + 4;
  localparam int unsigned ProdBits = CoordBits + WBits;

  logic signed [AccBits-1:0]  acc_q [3];
  logic signed [ProdBits-1:0] prod  [3];

  // tap times weight, full width
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod[c] = $signed(tap_i[c*CoordBits +: CoordBits]) * w_i;
    end
  end

  // multiply-accumulate per coordinate
  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      if (clr_i) begin
        acc_q[c] <= '0;
      end else if (acc_i) begin
        acc_q[c] <= acc_q[c] + AccBits'(prod[c]);
      end
    end
  end

  // floor divide by 16, optional subtract, saturate
  always_comb begin
    logic signed [AccBits-1:0] f;
    logic signed [AccBits-1:0] hi;
    logic signed [AccBits-1:0] lo;
    hi = AccBits'({1'b0, {(CoordBits-1){1'b1}}});
    lo = -hi - AccBits'(1);
    res_o = '0;
    for (int c = 0; c < 3; c++) begin
      f = acc_q[c] >>> 4;
      if (sub_i) begin
        f = f - AccBits'($signed(ctr_i[c*CoordBits +: CoordBits]));
      end
      if (f > hi) begin
        f = hi;
      end else if (f < lo) begin
        f = lo;
      end
      res_o[c*CoordBits +: CoordBits] = f[CoordBits-1:0];
    end
  end

endmodule
`default_nettype wire

// ===== src/five_tap_point_curve_filter.sv =====
// A write goes into the point store when it is accepted; a read word passes the
// registered store read and the output register, and no request is taken meanwhile.
// A run pass steps each point through fetch, calc and write-back, or only write-back
// outside the range; in-place repeats it iteration_count times before the acknowledge.
// Reset (async, active low) clears control and loads register defaults;
// stores are undefined until written.
// ============================================================================
// five_tap_point_curve_filter: top level of the five-tap point curve filter
// Point and displacement stores with a tap sequencer and one output register.
// ============================================================================
`default_nettype none
module five_tap_point_curve_filter
  import ftpcf_pkg::*;
#(
  parameter int unsigned MaxPoints = MaxPointsDef,
  parameter int unsigned CoordBits = CoordBitsDef
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    s_axis_tvalid,
  output logic                         s_axis_tready,
  // req_type[1:0], point_index[11:2], in_x, in_y, in_z from bit 12 up
  input  wire logic [((12+3*CoordBits+7)/8)*8-1:0] s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  wire logic                    m_axis_tready,
  // out_x, out_y, out_z from bit 0 up
  output logic [((3*CoordBits+7)/8)*8-1:0] m_axis_tdata,
  // run_done
  output logic                         m_axis_tuser,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [CfgIdxBits-1:0]   cfg_index,
  input  wire logic [CfgDataBits-1:0]  cfg_data
);

  localparam int unsigned AW  = $clog2(MaxPoints);
  localparam int unsigned PW  = 3*CoordBits;
  localparam int unsigned OW  = ((3*CoordBits+7)/8)*8;
  localparam int unsigned NW  = AW + 1;

  // configuration registers
  logic [CntBits-1:0] count_q;
  logic [1:0]         kernel_q;
  logic               mode_q;
  logic [7:0]         iter_q;
  logic [IdxBits-1:0] first_q, last_q;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= CntBits'(1024);
      kernel_q <= '0;
      mode_q   <= 1'b0;
      iter_q   <= 8'd1;
      first_q  <= '0;
      last_q   <= IdxBits'(1023);
    end else if (cfg_valid) begin
      case (reg_e'(cfg_index))
        REG_COUNT:  count_q  <= cfg_data[CntBits-1:0];
        REG_KERNEL: kernel_q <= cfg_data[1:0];
        REG_MODE:   mode_q   <= cfg_data[0];
        REG_ITER:   iter_q   <= cfg_data[7:0];
        REG_FIRST:  first_q  <= cfg_data[IdxBits-1:0];
        REG_LAST:   last_q   <= cfg_data[IdxBits-1:0];
        default: ;
      endcase
    end
  end

  // input fields
  logic [ReqBits-1:0]   in_req;
  logic [IdxBits-1:0]   in_idx;
  logic [PW-1:0]        in_pt;
  assign in_req = s_axis_tdata[1:0];
  assign in_idx = s_axis_tdata[11:2];
  assign in_pt  = s_axis_tdata[12 +: PW];

  // derived run parameters
  logic [NW-1:0] n_eff;
  logic [1:0]    k_eff;
  always_comb begin
    if (count_q < CntBits'(4)) begin
      n_eff = NW'(4);
    end else if (32'(count_q) > MaxPoints) begin
      n_eff = NW'(MaxPoints);
    end else begin
      n_eff = NW'(count_q);
    end
    k_eff = (kernel_q == 2'd3) ? 2'd0 : kernel_q;
  end

  // sequencer state
  state_e        state_q, state_d;
  logic [NW-1:0] i_q, i_d;
  logic [7:0]    pass_q, pass_d;
  logic [2:0]    tap_q, tap_d;
  logic          rd_pend_q;
  logic [2:0]    rd_tap_q;
  logic          out_valid_q;
  logic [OW-1:0] out_data_q;
  logic          out_user_q;
  logic          rd_fwd_q;
  logic          rd_idx_ok_q;

  // memories
  logic          p_we, d_we;
  logic [AW-1:0] p_waddr, p_raddr, d_waddr, d_raddr;
  logic [PW-1:0] p_wdata, p_rdata, d_wdata, d_rdata;
  logic [PW-1:0] res;
  logic [AW-1:0] d_waddr_f;
  logic          d_we_f;
  logic [PW-1:0] d_wdata_f;

  ftpcf_mem #(.Depth(MaxPoints), .Width(PW)) u_pmem (
    .clk_i, .we_i(p_we), .waddr_i(p_waddr), .wdata_i(p_wdata),
    .raddr_i(p_raddr), .rdata_o(p_rdata)
  );
  ftpcf_mem #(.Depth(MaxPoints), .Width(PW)) u_dmem (
    .clk_i, .we_i(d_we_f), .waddr_i(d_waddr_f), .wdata_i(d_wdata_f),
    .raddr_i(d_raddr), .rdata_o(d_rdata)
  );

  // tap address and weight for current index
  logic          is_lo, is_hi, in_rng;
  logic [NW-1:0] tap_addr;
  weight_t       tap_w, rd_w;
  logic [2:0]    ntaps;
  always_comb begin
    is_lo  = (i_q == NW'(1));
    is_hi  = (i_q == n_eff - NW'(2));
    in_rng = mode_q ? ((i_q >= NW'(first_q)) && (i_q <= NW'(last_q))) : 1'b1;
    ntaps  = (is_lo || is_hi) ? 3'd4 : 3'd5;
    if (is_lo) begin
      tap_addr = NW'(tap_q);
    end else if (is_hi) begin
      tap_addr = n_eff - NW'(1) - NW'(tap_q);
    end else begin
      tap_addr = i_q - NW'(2) + NW'(tap_q);
    end
  end
  always_comb begin
    if (is_lo || is_hi) begin
      rd_w = edge_weight(k_eff, rd_tap_q);
    end else begin
      rd_w = mid_weight(k_eff, rd_tap_q);
    end
  end
  assign tap_w = rd_w;

  logic start_ok;
  assign start_ok = (iter_q != 8'd0) && (first_q <= last_q);

  // next state
  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    pass_d  = pass_q;
    tap_d   = tap_q;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid && s_axis_tready && in_req == REQ_RUN) begin
          i_d    = NW'(1);
          pass_d = '0;
          tap_d  = '0;
          if (!mode_q || start_ok) begin
            state_d = ST_FETCH;
          end else begin
            state_d = ST_ACK;
          end
        end
      end
      ST_FETCH: begin
        if (!in_rng) begin
          state_d = ST_WRITE;
        end else if (tap_q == ntaps - 3'd1) begin
          state_d = ST_CALC;
        end else begin
          tap_d = tap_q + 3'd1;
        end
      end
      ST_CALC: begin
        if (!rd_pend_q) begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        tap_d = '0;
        if (i_q == n_eff - NW'(2)) begin
          i_d = NW'(1);
          if (!mode_q || pass_q + 8'd1 == iter_q) begin
            state_d = ST_ACK;
          end else begin
            pass_d  = pass_q + 8'd1;
            state_d = ST_FETCH;
          end
        end else begin
          i_d     = i_q + NW'(1);
          state_d = ST_FETCH;
        end
      end
      ST_ACK: begin
        if (!out_valid_q) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // memory port control
  logic acc_en, clr_en, wr_disp_ends;
  always_comb begin
    s_axis_tready = (state_q == ST_IDLE) && !rd_pend_q && !rd_fwd_q
                    && (!out_valid_q || m_axis_tready);
    p_we    = 1'b0;
    p_waddr = AW'(in_idx);
    p_wdata = in_pt;
    p_raddr = AW'(in_idx);
    d_we    = 1'b0;
    d_waddr = AW'(i_q);
    d_wdata = res;
    d_raddr = AW'(in_idx);
    acc_en  = rd_pend_q && (rd_tap_q != 3'd7);
    clr_en  = 1'b0;
    wr_disp_ends = 1'b0;
    case (state_q)
      ST_IDLE: begin
        clr_en = 1'b1;
        if (s_axis_tvalid && s_axis_tready && in_req == REQ_WRITE
            && 32'(in_idx) < MaxPoints) begin
          p_we = 1'b1;
        end
        // first end zero of the displacement store
        if (s_axis_tvalid && s_axis_tready && in_req == REQ_RUN && !mode_q) begin
          d_we    = 1'b1;
          d_waddr = '0;
          d_wdata = '0;
        end
      end
      ST_FETCH: begin
        p_raddr = AW'(tap_addr);
      end
      ST_CALC: begin
        p_raddr = AW'(i_q);
      end
      ST_WRITE: begin
        clr_en = 1'b1;
        acc_en = 1'b0;
        if (in_rng) begin
          if (mode_q) begin
            p_we    = 1'b1;
            p_waddr = AW'(i_q);
            p_wdata = res;
          end else begin
            d_we = 1'b1;
          end
        end
      end
      ST_ACK: begin
        if (!mode_q && !out_valid_q) begin
          wr_disp_ends = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // read-pending tracking; tap index 7 marks the center fetch
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pend_q <= 1'b0;
      rd_tap_q  <= '0;
    end else begin
      rd_pend_q <= (state_q == ST_FETCH && in_rng) || (state_q == ST_CALC && !rd_pend_q);
      rd_tap_q  <= (state_q == ST_CALC) ? 3'd7 : tap_q;
    end
  end

  // center point arrives from the store in the write-back cycle
  ftpcf_mac #(.CoordBits(CoordBits)) u_mac (
    .clk_i, .clr_i(clr_en), .acc_i(acc_en), .w_i(tap_w), .tap_i(p_rdata),
    .sub_i(!mode_q), .ctr_i(p_rdata), .res_o(res)
  );

  // last-end zero written during ACK
  always_comb begin
    d_we_f    = d_we;
    d_waddr_f = d_waddr;
    d_wdata_f = d_wdata;
    if (wr_disp_ends) begin
      d_we_f    = 1'b1;
      d_waddr_f = AW'(n_eff - NW'(1));
      d_wdata_f = '0;
    end
  end

  // sequencer and output registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      i_q         <= '0;
      pass_q      <= '0;
      tap_q       <= '0;
      out_valid_q <= 1'b0;
      out_user_q  <= 1'b0;
      rd_fwd_q    <= 1'b0;
      rd_idx_ok_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      i_q      <= i_d;
      pass_q   <= pass_d;
      tap_q    <= tap_d;
      rd_fwd_q <= s_axis_tvalid && s_axis_tready && in_req == REQ_READ;
      rd_idx_ok_q <= 32'(in_idx) < MaxPoints;
      if (rd_fwd_q) begin
        out_valid_q <= 1'b1;
        out_user_q  <= 1'b0;
      end else if (state_q == ST_ACK && !out_valid_q) begin
        out_valid_q <= 1'b1;
        out_user_q  <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_fwd_q) begin
      out_data_q <= rd_idx_ok_q ? OW'(mode_q ? p_rdata : d_rdata) : '0;
    end else if (state_q == ST_ACK && !out_valid_q) begin
      out_data_q <= '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule
`default_nettype wire

// ===== src/ftpcf_checker.sv =====
// ============================================================================
// ftpcf_checker: port-level checks of the point curve filter
// Output holding and request/result ordering seen at the ports.
// ============================================================================
`default_nettype none
module ftpcf_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic s_axis_tvalid,
  input wire logic s_axis_tready,
  input wire logic m_axis_tvalid,
  input wire logic m_axis_tready,
  input wire logic m_axis_tuser
);

  // a stalled word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output word dropped while stalled");

  // run acknowledge holds its flag while stalled
  a_user: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tuser))
    else $error("run_done changed while stalled");

  // no new request while a run acknowledge waits
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while run acknowledge pending");

endmodule

bind five_tap_point_curve_filter ftpcf_checker u_chk (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tuser
);
`default_nettype wire

// ===== bench/curve_filter_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// curve_filter_checker: result predictor and comparator of the curve filter
// Watches the request, result and register channels, keeps its own copy of
// both point stores and the registers, and compares every result word.
// ============================================================================
module curve_filter_checker
  import ftpcf_pkg::*;
(
  input  logic          clk_i,
  input  logic          s_axis_tvalid,
  input  logic          s_axis_tready,
  input  logic [111:0]  s_axis_tdata,
  input  logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  input  logic [95:0]   m_axis_tdata,
  input  logic          m_axis_tuser,
  input  logic          cfg_valid,
  input  logic          cfg_ready,
  input  logic [2:0]    cfg_index,
  input  logic [15:0]   cfg_data,
  output int            results_waiting_o,
  output int            mismatch_count_o
);

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               done;
  } curve_word_t;

  curve_word_t        expected_words[$];
  logic signed [31:0] pts  [1024][3];
  logic signed [31:0] disp [1024][3];
  logic [10:0]        cnt_q;
  logic [1:0]         kern_q;
  logic               mode_q;
  logic [7:0]         iter_q;
  logic [9:0]         first_q;
  logic [9:0]         last_q;

  initial begin
    results_waiting_o = 0;
    mismatch_count_o  = 0;
    cnt_q   = 11'd1024;
    kern_q  = 2'd0;
    mode_q  = 1'b0;
    iter_q  = 8'd1;
    first_q = 10'd0;
    last_q  = 10'd1023;
    for (int i = 0; i < 1024; i++)
      for (int c = 0; c < 3; c++) begin
        pts[i][c]  = '0;
        disp[i][c] = '0;
      end
  end

  // kernel tap weights, boundary taps start at the end point
  function automatic longint tap_weight(int k, bit at_end, int t);
    if (at_end) begin
      case (k)
        1:       return (t == 0) ? 6 : (t == 1) ? 5 : (t == 2) ? 4 : 1;
        2:       return (t == 0) ? -6 : (t == 1) ? 27 : (t == 2) ? -4 : -1;
        default: return (t == 0) ? 2 : (t == 1) ? 11 : (t == 2) ? 4 : -1;
      endcase
    end
    case (k)
      1:       return (t == 0 || t == 4) ? 1 : (t == 1 || t == 3) ? 4 : 6;
      2:       return (t == 0 || t == 4) ? -1 : (t == 1 || t == 3) ? -4 : 26;
      default: return (t == 0 || t == 4) ? -1 : (t == 1 || t == 3) ? 4 : 10;
    endcase
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // floor of the weighted sum over 16 at index i
  function automatic longint filtered_at(int n, int k, int i, int c);
    longint s;
    s = 0;
    if (i == 1) begin
      for (int t = 0; t < 4; t++) s += tap_weight(k, 1'b1, t) * longint'(pts[t][c]);
    end else if (i == n - 2) begin
      for (int t = 0; t < 4; t++)
        s += tap_weight(k, 1'b1, t) * longint'(pts[n - 1 - t][c]);
    end else begin
      for (int t = 0; t < 5; t++)
        s += tap_weight(k, 1'b0, t) * longint'(pts[i - 2 + t][c]);
    end
    return s >>> 4;
  endfunction

  task automatic run_filter_pass();
    int n;
    int k;
    n = cnt_q;
    k = (kern_q == 2'd3) ? 0 : kern_q;
    if (n < 4) n = 4;
    if (n > 1024) n = 1024;
    if (!mode_q) begin
      for (int c = 0; c < 3; c++) begin
        disp[0][c]     = '0;
        disp[n - 1][c] = '0;
      end
      for (int i = 1; i <= n - 2; i++)
        for (int c = 0; c < 3; c++)
          disp[i][c] = 32'(clip32(filtered_at(n, k, i, c) - longint'(pts[i][c])));
    end else begin
      for (int j = 0; j < iter_q; j++)
        for (int i = 1; i <= n - 2; i++)
          if (i >= first_q && i <= last_q)
            for (int c = 0; c < 3; c++) pts[i][c] = 32'(clip32(filtered_at(n, k, i, c)));
    end
  endtask

  task automatic predict_request(logic [111:0] d);
    curve_word_t w;
    int          idx;
    idx = d[11:2];
    w   = '0;
    case (req_e'(d[1:0]))
      REQ_WRITE: begin
        pts[idx][0] = d[43:12];
        pts[idx][1] = d[75:44];
        pts[idx][2] = d[107:76];
      end
      REQ_RUN: begin
        run_filter_pass();
        w.done = 1'b1;
        expected_words.push_back(w);
      end
      REQ_READ: begin
        w.x = mode_q ? pts[idx][0] : disp[idx][0];
        w.y = mode_q ? pts[idx][1] : disp[idx][1];
        w.z = mode_q ? pts[idx][2] : disp[idx][2];
        expected_words.push_back(w);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i) begin
    curve_word_t got;
    curve_word_t want;
    // register word
    if (cfg_valid && cfg_ready) begin
      case (reg_e'(cfg_index))
        REG_COUNT:  cnt_q   = cfg_data[10:0];
        REG_KERNEL: kern_q  = cfg_data[1:0];
        REG_MODE:   mode_q  = cfg_data[0];
        REG_ITER:   iter_q  = cfg_data[7:0];
        REG_FIRST:  first_q = cfg_data[9:0];
        REG_LAST:   last_q  = cfg_data[9:0];
        default: ;
      endcase
    end
    // request word
    if (s_axis_tvalid && s_axis_tready) predict_request(s_axis_tdata);
    // result word
    if (m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64], m_axis_tuser};
      if (expected_words.size() == 0) begin
        $error("unexpected result word x=%0d done=%0b", got.x, got.done);
        mismatch_count_o++;
      end else begin
        want = expected_words.pop_front();
        if (got.x !== want.x) begin
          $error("out_x expected %0d actual %0d", want.x, got.x);
          mismatch_count_o++;
        end
        if (got.y !== want.y) begin
          $error("out_y expected %0d actual %0d", want.y, got.y);
          mismatch_count_o++;
        end
        if (got.z !== want.z) begin
          $error("out_z expected %0d actual %0d", want.z, got.z);
          mismatch_count_o++;
        end
        if (got.done !== want.done) begin
          $error("run_done expected %0b actual %0b", want.done, got.done);
          mismatch_count_o++;
        end
      end
    end
    results_waiting_o = expected_words.size();
  end

endmodule

// ===== bench/five_tap_point_curve_filter_test.sv =====
`timescale 1ns / 1ps
// ============================================================================
// five_tap_point_curve_filter_test: stimulus and verdict for the curve filter
// Directed requests on a four-point curve, then random phases that change
// the registers while idle, fill the curve and mix writes, runs and reads.
// ============================================================================
module five_tap_point_curve_filter_test
  import ftpcf_pkg::*;
;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  // req_type, point_index, in_x, in_y, in_z from bit 0 up
  logic [111:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  // out_x, out_y, out_z from bit 0 up
  logic [95:0]  m_axis_tdata;
  // run_done
  logic         m_axis_tuser;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [2:0]   cfg_index;
  logic [15:0]  cfg_data;
  int           results_waiting;
  int           mismatch_count;

  int           send_idle_pct;
  int           recv_stall_pct;
  bit           hold_req;
  bit           pt_written   [1024];
  bit           disp_written [1024];
  int           cur_n;
  bit           cur_mode;
  int           item_total;

  five_tap_point_curve_filter dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  curve_filter_checker checker_u (
    .clk_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .results_waiting_o(results_waiting), .mismatch_count_o(mismatch_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(12ns * 10000000);
    $display("Mismatches found");
    $finish;
  end

  // receiver side, with one long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_req = 1'b0;
      end
      m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return ($urandom_range(0, 3) == 0) ? 32'h7fffffff :
                ($urandom_range(0, 2) == 0) ? 32'h80000000 :
                ($urandom_range(0, 1) == 0) ? 32'hffffffff : 32'h0;
      default: return 32'($urandom_range(0, 32'h3fffff)) - 32'h200000;
    endcase
  endfunction

  task automatic send_word(logic [1:0] req, logic [9:0] idx,
                           logic [31:0] x, logic [31:0] y, logic [31:0] z);
    bit rdy;
    if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, z, y, x, idx, req};
    do begin
      @(negedge clk_i);
      rdy = s_axis_tready;
      @(posedge clk_i);
    end while (!rdy);
    if (req != REQ_NONE) item_total++;
    if (req == REQ_WRITE) pt_written[idx] = 1'b1;
    if (req == REQ_RUN && !cur_mode)
      for (int i = 0; i < cur_n; i++) disp_written[i] = 1'b1;
  endtask

  // sample the waiting count away from the clock edge
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (results_waiting != 0) @(negedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_e r, int v);
    bit rdy;
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data  <= 16'(v);
    do begin
      @(negedge clk_i);
      rdy = cfg_ready;
      @(posedge clk_i);
    end while (!rdy);
    cfg_valid <= 1'b0;
    if (r == REG_COUNT) cur_n = (v[10:0] < 4) ? 4 : (v[10:0] > 1024) ? 1024 : v[10:0];
    if (r == REG_MODE) cur_mode = v[0];
  endtask

  task automatic read_word(int idx);
    send_word(REQ_READ, 10'(idx), $urandom(), $urandom(), $urandom());
  endtask

  // one random request, reads only of written entries
  task automatic random_request();
    int r;
    int idx;
    r   = $urandom_range(0, 99);
    idx = $urandom_range(0, cur_n - 1);
    if (r < 40) begin
      if ($urandom_range(0, 19) == 0) idx = $urandom_range(0, 1023);
      send_word(REQ_WRITE, 10'(idx), pick_coord(), pick_coord(), pick_coord());
    end else if (r < 52) begin
      send_word(REQ_RUN, 10'($urandom()), $urandom(), $urandom(), $urandom());
    end else if (r < 95) begin
      if ((cur_mode && pt_written[idx]) || (!cur_mode && disp_written[idx])) read_word(idx);
      else send_word(REQ_RUN, 10'($urandom()), $urandom(), $urandom(), $urandom());
    end else begin
      send_word(REQ_NONE, 10'($urandom()), $urandom(), $urandom(), $urandom());
    end
  endtask

  initial begin
    int phase;
    int n_raw;
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b0;
    cur_n          = 1024;
    cur_mode       = 1'b0;
    item_total     = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // directed: four-point curve with extreme coordinates
    write_reg(REG_COUNT, 2);
    write_reg(REG_KERNEL, 2);
    write_reg(REG_MODE, 0);
    send_word(REQ_WRITE, 10'd0, 32'h80000000, 32'h7fffffff, 32'h0);
    send_word(REQ_WRITE, 10'd1, 32'h7fffffff, 32'h80000000, 32'hffffffff);
    send_word(REQ_WRITE, 10'd2, 32'h80000000, 32'h7fffffff, 32'h1);
    send_word(REQ_WRITE, 10'd3, 32'h7fffffff, 32'h80000000, 32'hfffffff1);
    send_word(REQ_WRITE, 10'd1023, 32'h12345678, 32'h9abcdef0, 32'h0);
    send_word(REQ_RUN, 10'd0, '0, '0, '0);
    for (int i = 0; i < 4; i++) read_word(i);
    send_word(REQ_NONE, 10'h3ff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    wait_idle();
    write_reg(REG_KERNEL, 3);
    write_reg(REG_MODE, 1);
    write_reg(REG_ITER, 0);
    send_word(REQ_RUN, 10'd0, '0, '0, '0);
    read_word(1);
    read_word(1023);
    wait_idle();
    write_reg(REG_ITER, 3);
    write_reg(REG_FIRST, 2);
    write_reg(REG_LAST, 1);
    send_word(REQ_RUN, 10'd0, '0, '0, '0);
    read_word(2);
    wait_idle();
    write_reg(REG_FIRST, 0);
    write_reg(REG_LAST, 1023);
    write_reg(REG_KERNEL, 1);
    send_word(REQ_RUN, 10'd0, '0, '0, '0);
    read_word(1);
    read_word(2);
    wait_idle();

    // random phases
    phase = 0;
    while (item_total < 1850) begin
      wait_idle();
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      if (phase == 3 || phase == 11) n_raw = $urandom_range(1024, 2047);
      else if (phase % 7 == 5) n_raw = $urandom_range(0, 3);
      else n_raw = $urandom_range(4, 40);
      write_reg(REG_COUNT, ($urandom_range(0, 31) << 11) | n_raw);
      write_reg(REG_KERNEL, $urandom());
      write_reg(REG_MODE, $urandom());
      if (cur_n > 40) write_reg(REG_ITER, $urandom_range(0, 1));
      else if (phase == 6) write_reg(REG_ITER, 255);
      else write_reg(REG_ITER, $urandom_range(0, 4));
      write_reg(REG_FIRST, ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 3));
      write_reg(REG_LAST, ($urandom_range(0, 3) == 0) ? $urandom() :
                          ($urandom_range(0, 1) == 0) ? 1023 : $urandom_range(0, cur_n));
      for (int i = 0; i < cur_n; i++)
        send_word(REQ_WRITE, 10'(i), pick_coord(), pick_coord(), pick_coord());
      if (phase == 2) hold_req = 1'b1;
      for (int j = 0; j < ((cur_n > 40) ? 6 : 40); j++) begin
        if (phase == 4 && j == 20) wait_idle();
        random_request();
      end
      phase++;
    end
    wait_idle();
    repeat (50) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
